// ===== rtl/ring_leader_election_node_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ring leader election node assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef RING_LEADER_ELECTION_NODE_UNIT_ASSERT_SVH
`define RING_LEADER_ELECTION_NODE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising edge outside reset
`define RLEN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define RLEN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RLEN_ASSERT(label, clk, rst_n, prop, msg)
`define RLEN_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/rlen_pkg.sv =====
// ----------------------------------------------------------------------------
// rlen_pkg
// shared types and codes of the ring leader election node
// ----------------------------------------------------------------------------
package rlen_pkg;

  // width of message values, ids and addresses on the ports
  localparam int VALUE_W = 16;
  localparam int CFG_IDX_W = 2;

  // request codes carried in in_tuser
  typedef enum logic [1:0] {
    REQ_ELECTION = 2'd0,
    REQ_SHUTDOWN = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_START    = 2'd3
  } req_e_t;

  // node status, one-hot
  typedef enum logic [2:0] {
    ST_ACTIVE  = 3'b001,
    ST_PASSIVE = 3'b010,
    ST_LEADER  = 3'b100
  } node_state_t;

  // reported status codes
  localparam logic [1:0] STATUS_ACTIVE  = 2'd0;
  localparam logic [1:0] STATUS_PASSIVE = 2'd1;
  localparam logic [1:0] STATUS_LEADER  = 2'd2;

  // message kinds and sides
  localparam logic KIND_ELECTION = 1'b0;
  localparam logic KIND_SHUTDOWN = 1'b1;
  localparam logic SIDE_LEFT     = 1'b0;
  localparam logic SIDE_RIGHT    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ADDR = 2'd2;

  // configuration values
  typedef struct packed {
    logic [VALUE_W-1:0] own_id;
    logic [VALUE_W-1:0] own_addr;
    logic [VALUE_W-1:0] right_addr;
  } cfg_t;

  // one queued election message
  typedef struct packed {
    logic               right;
    logic [VALUE_W-1:0] value;
    logic               parity;
  } msg_t;

  // queue requests from the node logic
  typedef struct packed {
    logic a_en;
    msg_t a;
    logic b_en;
    msg_t b;
    logic pop;
  } q_req_t;

  // queue head as seen by the node logic
  typedef struct packed {
    logic has_msg;
    msg_t head;
  } q_stat_t;

  // one result item
  typedef struct packed {
    logic               send_valid;
    logic               send_right;
    logic               send_kind;
    logic [VALUE_W-1:0] send_value;
    logic               send_parity;
    logic [1:0]         node_status;
    logic               finished;
    logic               queue_overflow;
  } result_t;

endpackage

// ===== rtl/rlen_queue.sv =====
// ----------------------------------------------------------------------------
// rlen_queue
// send queue: fills the lowest free slots, sends from the lowest occupied one
// ----------------------------------------------------------------------------
`include "ring_leader_election_node_unit_assert.svh"

module rlen_queue
  import rlen_pkg::*;
#(
  parameter int QUEUE_SLOTS = 8,
  parameter int ID_BITS     = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_req_t  q_req,
  output q_stat_t q_stat,
  output logic    q_drop
);

  localparam int ID_W  = (ID_BITS < VALUE_W) ? ID_BITS : VALUE_W;
  localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  logic [QUEUE_SLOTS-1:0] valid_r;
  logic [QUEUE_SLOTS-1:0] valid_nxt;
  logic                   slot_right_r [QUEUE_SLOTS];
  logic [ID_W-1:0]        slot_id_r    [QUEUE_SLOTS];
  logic                   slot_par_r   [QUEUE_SLOTS];

  logic [QUEUE_SLOTS-1:0] free2_mask;
  logic [IDX_W-1:0]       free1_idx;
  logic [IDX_W-1:0]       free2_idx;
  logic [IDX_W-1:0]       pick_idx;
  logic [IDX_W-1:0]       b_idx;
  logic                   free1_found;
  logic                   free2_found;
  logic                   pick_found;
  logic                   b_found;
  logic                   a_wr;
  logic                   b_wr;

  // lowest free slot, lowest occupied slot
  always_comb begin
    free1_idx   = '0;
    free1_found = 1'b0;
    pick_idx    = '0;
    pick_found  = 1'b0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free1_idx   = IDX_W'(i);
        free1_found = 1'b1;
      end
      if (valid_r[i]) begin
        pick_idx   = IDX_W'(i);
        pick_found = 1'b1;
      end
    end
  end

  // second lowest free slot
  always_comb begin
    free2_mask = ~valid_r;
    free2_mask[free1_idx] = 1'b0;
    free2_idx   = '0;
    free2_found = 1'b0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (free2_mask[i]) begin
        free2_idx   = IDX_W'(i);
        free2_found = 1'b1;
      end
    end
  end

  // slot targets and drop flag
  always_comb begin
    b_idx   = q_req.a_en ? free2_idx : free1_idx;
    b_found = q_req.a_en ? free2_found : free1_found;
    a_wr    = q_req.a_en && free1_found;
    b_wr    = q_req.b_en && b_found;
    q_drop  = (q_req.a_en && !free1_found) || (q_req.b_en && !b_found);
  end

  // valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (q_req.pop) begin
      valid_nxt[pick_idx] = 1'b0;
    end
    if (a_wr) begin
      valid_nxt[free1_idx] = 1'b1;
    end
    if (b_wr) begin
      valid_nxt[b_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (a_wr) begin
      slot_right_r[free1_idx] <= q_req.a.right;
      slot_id_r[free1_idx]    <= q_req.a.value[ID_W-1:0];
      slot_par_r[free1_idx]   <= q_req.a.parity;
    end
    if (b_wr) begin
      slot_right_r[b_idx] <= q_req.b.right;
      slot_id_r[b_idx]    <= q_req.b.value[ID_W-1:0];
      slot_par_r[b_idx]   <= q_req.b.parity;
    end
  end

  // head of the queue
  always_comb begin
    q_stat.has_msg     = pick_found;
    q_stat.head.right  = slot_right_r[pick_idx];
    q_stat.head.value  = VALUE_W'(slot_id_r[pick_idx]);
    q_stat.head.parity = slot_par_r[pick_idx];
  end

  // checks
  `RLEN_ASSERT(a_pop_needs_msg, clk, rst_n, q_req.pop |-> pick_found, "pop from empty queue")
  `RLEN_ASSERT(a_drop_when_full, clk, rst_n, q_drop |=> ($past(valid_r) == valid_r) || $past(a_wr), "drop changed the queue")

endmodule

// ===== rtl/rlen_core.sv =====
// ----------------------------------------------------------------------------
// rlen_core
// election state of the node and the decision made for each transaction
// ----------------------------------------------------------------------------
`include "ring_leader_election_node_unit_assert.svh"

module rlen_core
  import rlen_pkg::*;
#(
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  cfg_t               cfg,
  input  logic [1:0]         req_type,
  input  logic               from_right,
  input  logic [VALUE_W-1:0] msg_value,
  input  logic               msg_parity,
  input  logic               link_ready,
  input  q_stat_t            q_stat,
  input  logic               q_drop,
  output q_req_t             q_req,
  output result_t            result
);

  localparam int ID_W = (ID_BITS < VALUE_W) ? ID_BITS : VALUE_W;

  node_state_t     state_r, state_nxt;
  logic            parity_r, parity_nxt;
  logic [1:0]      echo_r, echo_nxt;
  logic            done_r, done_nxt;
  logic [ID_W-1:0] heard_r   [4];
  logic [ID_W-1:0] heard_nxt [4];

  logic [ID_W-1:0] me;
  logic [ID_W-1:0] id;
  logic [ID_W-1:0] hl;
  logic [ID_W-1:0] hr;
  logic [ID_W-1:0] nl;
  logic [ID_W-1:0] nr;
  q_req_t          req;
  req_e_t          req_code;

  function automatic logic [1:0] status_code(node_state_t s);
    logic [1:0] code;
    unique case (s)
      ST_ACTIVE:  code = STATUS_ACTIVE;
      ST_PASSIVE: code = STATUS_PASSIVE;
      ST_LEADER:  code = STATUS_LEADER;
      default:    code = STATUS_ACTIVE;
    endcase
    return code;
  endfunction

  assign me       = cfg.own_id[ID_W-1:0];
  assign id       = msg_value[ID_W-1:0];
  assign req_code = req_e_t'(req_type);
  assign hl       = heard_r[{parity_r, SIDE_LEFT}];
  assign hr       = heard_r[{parity_r, SIDE_RIGHT}];
  assign nl       = heard_r[{~parity_r, SIDE_LEFT}];
  assign nr       = heard_r[{~parity_r, SIDE_RIGHT}];

  // decision for one transaction
  always_comb begin
    state_nxt  = state_r;
    parity_nxt = parity_r;
    echo_nxt   = echo_r;
    done_nxt   = done_r;
    for (int i = 0; i < 4; i++) begin
      heard_nxt[i] = heard_r[i];
    end
    req    = '0;
    result = '0;
    unique case (req_code)
      REQ_ELECTION: begin
        if (id == me) begin
          echo_nxt = (echo_r != 2'd3) ? echo_r + 2'd1 : echo_r;
          if (echo_nxt == 2'd2) begin
            state_nxt         = ST_LEADER;
            result.send_valid = 1'b1;
            result.send_right = SIDE_RIGHT;
            result.send_kind  = KIND_SHUTDOWN;
            result.send_value = cfg.own_addr;
          end
        end else if (state_r == ST_PASSIVE) begin
          // relay to the opposite side
          req.a_en     = 1'b1;
          req.a.right  = ~from_right;
          req.a.value  = VALUE_W'(id);
          req.a.parity = msg_parity;
        end else if (state_r == ST_ACTIVE) begin
          heard_nxt[{msg_parity, from_right}] = id;
        end
      end
      REQ_SHUTDOWN: begin
        if (msg_value != cfg.right_addr) begin
          result.send_valid = 1'b1;
          result.send_right = SIDE_RIGHT;
          result.send_kind  = KIND_SHUTDOWN;
          result.send_value = msg_value;
        end
        done_nxt = 1'b1;
      end
      REQ_TICK: begin
        if (q_stat.has_msg) begin
          if (link_ready) begin
            result.send_valid  = 1'b1;
            result.send_right  = q_stat.head.right;
            result.send_kind   = KIND_ELECTION;
            result.send_value  = q_stat.head.value;
            result.send_parity = q_stat.head.parity;
            req.pop            = 1'b1;
          end
        end else if (state_r == ST_ACTIVE && hl != '0 && hr != '0) begin
          parity_nxt = ~parity_r;
          if (me > hl && me > hr) begin
            // won this round: announce both ways
            heard_nxt[{parity_r, SIDE_LEFT}]  = '0;
            heard_nxt[{parity_r, SIDE_RIGHT}] = '0;
            req.a_en     = 1'b1;
            req.a.right  = SIDE_LEFT;
            req.a.value  = VALUE_W'(me);
            req.a.parity = ~parity_r;
            req.b_en     = 1'b1;
            req.b.right  = SIDE_RIGHT;
            req.b.value  = VALUE_W'(me);
            req.b.parity = ~parity_r;
          end else begin
            // lost: go passive, pass on next-round ids already heard
            state_nxt    = ST_PASSIVE;
            req.a_en     = (nl != '0);
            req.a.right  = SIDE_RIGHT;
            req.a.value  = VALUE_W'(nl);
            req.a.parity = ~parity_r;
            req.b_en     = (nr != '0);
            req.b.right  = SIDE_LEFT;
            req.b.value  = VALUE_W'(nr);
            req.b.parity = ~parity_r;
          end
        end
      end
      REQ_START: begin
        if (state_r == ST_ACTIVE) begin
          req.a_en     = 1'b1;
          req.a.right  = SIDE_LEFT;
          req.a.value  = VALUE_W'(me);
          req.a.parity = parity_r;
          req.b_en     = 1'b1;
          req.b.right  = SIDE_RIGHT;
          req.b.value  = VALUE_W'(me);
          req.b.parity = parity_r;
        end
      end
      default: begin
      end
    endcase
    result.node_status    = status_code(state_nxt);
    result.finished       = done_nxt;
    result.queue_overflow = q_drop;
  end

  // queue requests only on an accepted transaction
  always_comb begin
    q_req      = req;
    q_req.a_en = req.a_en && fire;
    q_req.b_en = req.b_en && fire;
    q_req.pop  = req.pop && fire;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ACTIVE;
      parity_r <= 1'b0;
      echo_r   <= 2'd0;
      done_r   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        heard_r[i] <= '0;
      end
    end else if (fire) begin
      state_r  <= state_nxt;
      parity_r <= parity_nxt;
      echo_r   <= echo_nxt;
      done_r   <= done_nxt;
      for (int i = 0; i < 4; i++) begin
        heard_r[i] <= heard_nxt[i];
      end
    end
  end

  // checks
  `RLEN_ASSERT(a_leader_has_echoes, clk, rst_n, (state_r == ST_LEADER) |-> (echo_r >= 2'd2), "leader without two echoes")
  `RLEN_ASSERT(a_parity_on_tick, clk, rst_n, ($past(rst_n) && (parity_r != $past(parity_r))) |-> $past(fire && (req_type == REQ_TICK)), "round parity moved off a tick")

endmodule

// ===== rtl/ring_leader_election_node_unit.sv =====
// ----------------------------------------------------------------------------
// ring_leader_election_node_unit
// one node of a bidirectional ring electing a leader by id comparison
// ----------------------------------------------------------------------------
// Each input transaction carries one request (election message, shutdown
// message, tick or start) and yields exactly one result transaction that
// says whether a message is sent, where, and the node status afterwards.
// The request code travels in in_tuser, the message kind of a sent message
// in out_tuser.
// Results are registered: a transaction accepted at one edge shows its result
// on the output register right after that edge.
// Throughput is one transaction per cycle while the receiver takes results; the
// node state update and the queue slot search are done in the same cycle as acceptance.
// When the receiver stalls, the result register holds and in_tready drops
// until out_tready frees it; in_tready stays high while a result is taken.
// Reset (rst_n low at a rising edge) puts the node in active status, clears
// heard ids, round parity, echo count, shutdown flag and queue valid bits,
// and loads own_id 1, own_addr 0, right_addr 0.
// Configuration writes are taken at any edge with cfg_wr_en high; they
// belong in idle periods.
// ----------------------------------------------------------------------------
module ring_leader_election_node_unit
  import rlen_pkg::*;
#(
  parameter int QUEUE_SLOTS = 8,
  parameter int ID_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [0] from_right, [16:1] msg_value, [17] msg_parity, [18] link_ready
  input  logic [23:0]          in_tdata,
  // [1:0] req_type
  input  logic [1:0]           in_tuser,
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [0] send_valid, [1] send_right, [17:2] send_value, [18] send_parity,
  // [20:19] node_status, [21] finished, [22] queue_overflow
  output logic [23:0]          out_tdata,
  // [0] send_kind
  output logic                 out_tuser,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_wdata
);

  logic    fire;
  cfg_t    cfg_r;
  q_req_t  q_req;
  q_stat_t q_stat;
  logic    q_drop;
  result_t result;
  result_t out_r;
  logic    out_valid_r;

  // accept while the result register is empty or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id     <= VALUE_W'(1);
      cfg_r.own_addr   <= '0;
      cfg_r.right_addr <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_ID:     cfg_r.own_id     <= cfg_wdata;
        CFG_OWN_ADDR:   cfg_r.own_addr   <= cfg_wdata;
        CFG_RIGHT_ADDR: cfg_r.right_addr <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rlen_core #(
    .ID_BITS (ID_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cfg        (cfg_r),
    .req_type   (in_tuser),
    .from_right (in_tdata[0]),
    .msg_value  (in_tdata[16:1]),
    .msg_parity (in_tdata[17]),
    .link_ready (in_tdata[18]),
    .q_stat     (q_stat),
    .q_drop     (q_drop),
    .q_req      (q_req),
    .result     (result)
  );

  rlen_queue #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_req  (q_req),
    .q_stat (q_stat),
    .q_drop (q_drop)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.send_kind;
  assign out_tdata  = {1'b0, out_r.queue_overflow, out_r.finished, out_r.node_status,
                       out_r.send_parity, out_r.send_value, out_r.send_right,
                       out_r.send_valid};

  // checks
  `RLEN_ASSERT(a_fire_loads_result, clk, rst_n, fire |=> out_valid_r, "accepted transaction left no result")
  `RLEN_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
